[sv/mpq_pkg.sv]
// Package: payload types and mode codes for the min priority queue.
`timescale 1ns / 1ps
`default_nettype none
package mpq_pkg;
	localparam logic [1:0] MODE_PUSH  = 2'd0;
	localparam logic [1:0] MODE_POP   = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_PEEK  = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [31:0] top_value;
		logic        empty_res;
		logic [4:0]  occupancy;
		logic        overflow;
	} res_t;

	// Per-cycle command broadcast to every cell.
	typedef struct packed {
		logic        push;
		logic        pop;
		logic [31:0] key;
	} cell_ctl_t;

	// Sign-magnitude to ordered: a < b numerically.
	function automatic logic key_lt(input logic [31:0] a, input logic [31:0] b);
		logic signed [32:0] ka;
		logic signed [32:0] kb;
		begin
			ka = a[31] ? -$signed({2'b00, a[30:0]}) : $signed({2'b00, a[30:0]});
			kb = b[31] ? -$signed({2'b00, b[30:0]}) : $signed({2'b00, b[30:0]});
			key_lt = ka < kb;
		end
	endfunction
endpackage
`default_nettype wire

[sv/mpq_cell.sv]
// One sorted-array cell: holds a key, shifts with its neighbors on push and pop.
`timescale 1ns / 1ps
`default_nettype none
module mpq_cell (
	input  wire logic              clk,
	input  wire mpq_pkg::cell_ctl_t ctl,
	input  wire logic              is_head,
	input  wire logic              left_ins,
	input  wire logic [31:0]       left_key,
	input  wire logic [31:0]       right_key,
	input  wire logic              valid,
	output logic                   ins,
	output logic [31:0]            key_q
);
	import mpq_pkg::*;
	logic gt;

	// Insert here if new key goes before this entry (or slot is empty).
	assign gt  = is_head ? key_lt(ctl.key, key_q) : !key_lt(key_q, ctl.key);
	assign ins = left_ins | !valid | gt;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			if (left_ins)
				key_q <= left_key;
			else if (ins)
				key_q <= ctl.key;
		end else if (ctl.pop) begin
			key_q <= right_key;
		end
	end
endmodule
`default_nettype wire

[sv/min_priority_queue_core.sv]
// Top level: bounded min priority queue built as a chain of sorted cells.
//
//  channel | signals             | handshake
//  --------+---------------------+-------------------------------
//  command | start, busy, cmd    | taken when start & !busy
//  result  | res_valid, res      | one-cycle strobe, cannot stall
//
// In the accept cycle every cell compares the key and, on a push or pop, the
// array shifts in parallel at the accepting edge; in the next cycle the head
// and count are shown with the res_valid strobe. busy is high during the
// strobe cycle, so no command is taken then; a new command may follow the
// strobe cycle directly.
// Reset clears the count and control; cell keys are left undefined and are
// never shown unless written. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module min_priority_queue_core #(
	parameter int CAPACITY = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire mpq_pkg::cmd_t cmd,
	output logic               busy,
	output logic               res_valid,
	output mpq_pkg::res_t      res
);
	import mpq_pkg::*;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic          busy_q;
	logic          ovf_q;
	cell_ctl_t     ctl;
	logic          accept;
	logic          full;
	logic [31:0]   keys [CAPACITY];
	logic [CAPACITY-1:0] ins;

	assign accept = start && !busy_q;
	assign full   = count_q == CW'(CAPACITY);
	assign ctl.push = accept && cmd.mode == MODE_PUSH && !full;
	assign ctl.pop  = accept && cmd.mode == MODE_POP && count_q != '0;
	assign ctl.key  = cmd.value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic          l_ins;
		logic [31:0]   l_key;
		logic [31:0]   r_key;
		if (i == 0) begin : g_h
			assign l_ins = 1'b0;
			assign l_key = '0;
		end else begin : g_b
			assign l_ins = ins[i-1];
			assign l_key = keys[i-1];
		end
		if (i == CAPACITY - 1) begin : g_t
			assign r_key = keys[i];
		end else begin : g_m
			assign r_key = keys[i+1];
		end
		mpq_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.is_head  (i == 0),
			.left_ins (l_ins),
			.left_key (l_key),
			.right_key(r_key),
			.valid    (CW'(i) < count_q),
			.ins      (ins[i]),
			.key_q    (keys[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			busy_q <= accept;
			if (accept) begin
				ovf_q <= cmd.mode == MODE_PUSH && full;
				if (ctl.push)
					count_q <= count_q + 1'b1;
				else if (ctl.pop)
					count_q <= count_q - 1'b1;
				else if (cmd.mode == MODE_CLEAR)
					count_q <= '0;
			end
		end
	end

	assign busy      = busy_q;
	assign res_valid = busy_q;
	assign res.top_value = (count_q != '0) ? keys[0] : '0;
	assign res.empty_res = count_q == '0;
	assign res.occupancy = 5'(count_q);
	assign res.overflow  = ovf_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY)) else $error("count above capacity");
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid) else $error("missing result strobe");
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.overflow |-> res.occupancy == 5'(CAPACITY))
		else $error("overflow while not full");
	a_push_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |=> count_q == $past(count_q) + 1'b1) else $error("push lost");
`endif
endmodule
`default_nettype wire
